// ===== hdl/tut_pkg.sv =====
// Package for the tick-driven UART transceiver: sizes, register indexes,
// request and result layouts, engine handshake structs and a pointer helper.
// No dependencies.
`default_nettype none

package tut_pkg;

    localparam int CHAR_BITS  = 8;
    localparam int FIFO_DEPTH = 16;

    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SH_IDX_W   = (CHAR_BITS > 1) ? $clog2(CHAR_BITS) : 1;
    localparam int BIT_IDX_W  = 4;
    localparam int TPB_W      = 7;
    localparam int RX_CD_W    = 8;
    localparam int TX_CD_W    = TPB_W;
    localparam int BYTE_W     = 8;
    localparam int FILL_W     = 5;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TPB_W;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_BIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 1'd1;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // request: first field in the highest bit
    typedef struct packed {
        logic              rx_clear;
        logic              rx_pop;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_push;
        logic              rx_level;
    } req_t;

    localparam int REQ_W = $bits(req_t);

    typedef struct packed {
        logic              tx_busy;
        logic              tx_overflow;
        logic              rx_overflow;
        logic [FILL_W-1:0] tx_fill;
        logic [FILL_W-1:0] rx_fill;
        logic              rx_byte_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              tx_level;
    } rsp_t;

    localparam int RSP_W = $bits(rsp_t);

    // top -> bit engines, per tick
    typedef struct packed {
        logic              rx_level;
        logic              tx_push;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_avail;
        logic [BYTE_W-1:0] tx_head;
    } eng_in_t;

    // bit engines -> top, per tick
    typedef struct packed {
        logic              rx_push;
        logic [BYTE_W-1:0] rx_data;
        logic              tx_take;
        logic              tx_queue;
        logic              line;
        logic              busy;
    } eng_out_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/timer_tick_uart_transceiver.sv =====
// Top level of the tick-driven UART transceiver: stream handshake, FIFO
// pointers, config registers. Depends on tut_pkg, tut_fifo_mem, tut_engine.
//
//  port group   dir  width  contents
//  s_axis       in   16     one tick request: line level, push/byte, pop, clear
//  m_axis       out  24     one result per tick: line, popped byte, fills, flags
//  cfg          in   7      register writes, index 0 ticks_per_bit, 1 enable
//
//  One request per cycle unless m_tready stalls, one result per request.
//  A request is accepted while its FIFO entries are read from the byte
//  memories (registered read), and processed from the p1 stage into the output register.
//  The result goes through the p1 register and then the output register.
//  Reset empties both FIFOs and idles the engines; stored bytes are not cleared.
//  A stall on m_tready holds the pending request and stops s_tready.
`default_nettype none

module timer_tick_uart_transceiver (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [0] rx_level, [1] tx_push, [9:2] tx_byte, [10] rx_pop, [11] rx_clear
    input  wire logic [tut_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] tx_level, [8:1] rx_byte, [9] rx_byte_valid, [14:10] rx_fill,
    // [19:15] tx_fill, [20] rx_overflow, [21] tx_overflow, [22] tx_busy
    output logic      [tut_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tut_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tut_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tut_pkg::*;

    logic [TPB_W-1:0] tpb_reg;
    logic             enable_reg;

    logic             p1_valid_reg, p1_valid_next;
    req_t             p1_req_reg;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_rsp_reg;
    rsp_t             rsp;

    logic             s_fire;
    logic             p1_fire;

    logic [PTR_W-1:0] rx_rd_reg, rx_rd_mid, rx_rd_next;
    logic [PTR_W-1:0] rx_wr_reg, rx_wr_mid, rx_wr_next;
    logic [CNT_W-1:0] rx_cnt_reg, rx_cnt_mid, rx_cnt_next;
    logic [PTR_W-1:0] tx_rd_reg, tx_rd_mid, tx_rd_next;
    logic [PTR_W-1:0] tx_wr_reg, tx_wr_next;
    logic [CNT_W-1:0] tx_cnt_reg, tx_cnt_mid, tx_cnt_next;

    logic              got_valid;
    logic              rx_we, tx_we;
    logic              rx_ovf, tx_ovf;
    logic [BYTE_W-1:0] rx_rd_data, tx_rd_data;

    eng_in_t  eng_in;
    eng_out_t eng_out;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpb_reg    <= '0;
            enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TICKS_PER_BIT: tpb_reg    <= cfg_data[TPB_W-1:0];
                REG_ENABLE:        enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake
    assign p1_fire  = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_fire;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_fire) begin
            p1_valid_next = 1'b1;
        end else if (p1_fire) begin
            p1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (p1_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // engines
    assign eng_in.rx_level = p1_req_reg.rx_level;
    assign eng_in.tx_push  = p1_req_reg.tx_push;
    assign eng_in.tx_byte  = p1_req_reg.tx_byte;
    assign eng_in.tx_avail = (tx_cnt_reg != '0);
    assign eng_in.tx_head  = tx_rd_data;

    tut_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (p1_fire),
        .enable        (enable_reg),
        .ticks_per_bit (tpb_reg),
        .eng_in        (eng_in),
        .eng_out       (eng_out)
    );

    // receive FIFO: host side first, then the receiver's push
    always_comb begin
        rx_rd_mid  = rx_rd_reg;
        rx_wr_mid  = rx_wr_reg;
        rx_cnt_mid = rx_cnt_reg;
        got_valid  = 1'b0;
        if (p1_req_reg.rx_clear) begin
            rx_rd_mid  = '0;
            rx_wr_mid  = '0;
            rx_cnt_mid = '0;
        end else if (p1_req_reg.rx_pop && (rx_cnt_reg != '0)) begin
            rx_rd_mid  = ptr_inc(rx_rd_reg);
            rx_cnt_mid = rx_cnt_reg - 1'b1;
            got_valid  = 1'b1;
        end
        rx_we       = 1'b0;
        rx_ovf      = 1'b0;
        rx_wr_next  = rx_wr_mid;
        rx_cnt_next = rx_cnt_mid;
        if (eng_out.rx_push) begin
            if (rx_cnt_mid >= CNT_W'(FIFO_DEPTH)) begin
                rx_ovf = 1'b1;
            end else begin
                rx_we       = 1'b1;
                rx_wr_next  = ptr_inc(rx_wr_mid);
                rx_cnt_next = rx_cnt_mid + 1'b1;
            end
        end
        rx_rd_next = rx_rd_mid;
        if (!p1_fire) begin
            rx_rd_next  = rx_rd_reg;
            rx_wr_next  = rx_wr_reg;
            rx_cnt_next = rx_cnt_reg;
            rx_we       = 1'b0;
        end
    end

    // transmit FIFO: engine take first, then the queued push
    always_comb begin
        tx_rd_mid  = tx_rd_reg;
        tx_cnt_mid = tx_cnt_reg;
        if (eng_out.tx_take) begin
            tx_rd_mid  = ptr_inc(tx_rd_reg);
            tx_cnt_mid = tx_cnt_reg - 1'b1;
        end
        tx_we       = 1'b0;
        tx_ovf      = 1'b0;
        tx_wr_next  = tx_wr_reg;
        tx_cnt_next = tx_cnt_mid;
        if (eng_out.tx_queue) begin
            if (tx_cnt_mid >= CNT_W'(FIFO_DEPTH)) begin
                tx_ovf = 1'b1;
            end else begin
                tx_we       = 1'b1;
                tx_wr_next  = ptr_inc(tx_wr_reg);
                tx_cnt_next = tx_cnt_mid + 1'b1;
            end
        end
        tx_rd_next = tx_rd_mid;
        if (!p1_fire) begin
            tx_rd_next  = tx_rd_reg;
            tx_wr_next  = tx_wr_reg;
            tx_cnt_next = tx_cnt_reg;
            tx_we       = 1'b0;
        end
    end

    // heads are read at accept, from the pointers left by the request ahead
    tut_fifo_mem u_rx_mem (
        .aclk    (aclk),
        .wr_en   (rx_we),
        .wr_addr (rx_wr_mid),
        .wr_data (eng_out.rx_data),
        .rd_en   (s_fire),
        .rd_addr (rx_rd_next),
        .rd_data (rx_rd_data)
    );

    tut_fifo_mem u_tx_mem (
        .aclk    (aclk),
        .wr_en   (tx_we),
        .wr_addr (tx_wr_reg),
        .wr_data (p1_req_reg.tx_byte),
        .rd_en   (s_fire),
        .rd_addr (tx_rd_next),
        .rd_data (tx_rd_data)
    );

    always_comb begin
        rsp.tx_level      = eng_out.line;
        rsp.rx_byte       = got_valid ? rx_rd_data : '0;
        rsp.rx_byte_valid = got_valid;
        rsp.rx_fill       = FILL_W'(rx_cnt_next);
        rsp.tx_fill       = FILL_W'(tx_cnt_next);
        rsp.rx_overflow   = rx_ovf;
        rsp.tx_overflow   = tx_ovf;
        rsp.tx_busy       = eng_out.busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rx_rd_reg     <= '0;
            rx_wr_reg     <= '0;
            rx_cnt_reg    <= '0;
            tx_rd_reg     <= '0;
            tx_wr_reg     <= '0;
            tx_cnt_reg    <= '0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
            rx_rd_reg     <= rx_rd_next;
            rx_wr_reg     <= rx_wr_next;
            rx_cnt_reg    <= rx_cnt_next;
            tx_rd_reg     <= tx_rd_next;
            tx_wr_reg     <= tx_wr_next;
            tx_cnt_reg    <= tx_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_req_reg <= req_t'(s_tdata[REQ_W-1:0]);
        end
        if (p1_fire) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_rsp_reg);

    // checks
    a_fill_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (rx_cnt_reg <= CNT_W'(FIFO_DEPTH)) && (tx_cnt_reg <= CNT_W'(FIFO_DEPTH)))
        else $error("FIFO count beyond depth");

    a_take_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_fire && eng_out.tx_take) |-> (tx_cnt_reg != '0))
        else $error("transmit engine took from an empty FIFO");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_fire) |=> p1_valid_reg)
        else $error("pending request lost during stall");

    a_idle_line_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_fire && !enable_reg) |=> (out_valid_reg && out_rsp_reg.tx_level))
        else $error("line not high while disabled");

    a_ptr_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (rx_cnt_reg == '0) |-> (rx_rd_reg == rx_wr_reg))
        else $error("empty receive FIFO with unequal pointers");

endmodule

`default_nettype wire

// ===== hdl/tut_fifo_mem.sv =====
// Byte store for one FIFO: single write port, single registered read port.
// A read of the entry written in the same cycle returns the new byte.
// Depends on tut_pkg.
`default_nettype none

module tut_fifo_mem (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [tut_pkg::PTR_W-1:0] wr_addr,
    input  wire logic [tut_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [tut_pkg::PTR_W-1:0] rd_addr,
    output logic      [tut_pkg::BYTE_W-1:0] rd_data
);
    import tut_pkg::*;

    logic [BYTE_W-1:0] mem [FIFO_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data <= wr_data;
            end else begin
                rd_data <= mem[rd_addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tut_engine.sv =====
// Receive and transmit bit engines; one step per accepted tick.
// FIFO bookkeeping stays in the top level. Depends on tut_pkg.
`default_nettype none

module tut_engine (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     step,
    input  wire logic                     enable,
    input  wire logic [tut_pkg::TPB_W-1:0] ticks_per_bit,
    input  wire tut_pkg::eng_in_t         eng_in,
    output tut_pkg::eng_out_t             eng_out
);
    import tut_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_STOP = 2'd2;

    logic                 rx_active_reg, rx_active_next;
    logic [RX_CD_W-1:0]   rx_cd_reg, rx_cd_next;
    logic [BIT_IDX_W-1:0] rx_idx_reg, rx_idx_next;
    logic [CHAR_BITS-1:0] rx_shift_reg, rx_shift_next;

    logic [1:0]           tx_phase_reg, tx_phase_next;
    logic [TX_CD_W-1:0]   tx_cd_reg, tx_cd_next;
    logic [BIT_IDX_W-1:0] tx_idx_reg, tx_idx_next;
    logic [CHAR_BITS-1:0] tx_shift_reg, tx_shift_next;
    logic                 line_reg, line_next;

    logic [TPB_W-1:0]     t_eff;
    logic                 rx_push;
    logic                 tx_take;
    logic                 tx_queue;

    assign t_eff = (ticks_per_bit == '0) ? TPB_W'(1) : ticks_per_bit;

    // receiver
    always_comb begin
        rx_active_next = rx_active_reg;
        rx_cd_next     = rx_cd_reg;
        rx_idx_next    = rx_idx_reg;
        rx_shift_next  = rx_shift_reg;
        rx_push        = 1'b0;
        if (!enable) begin
            rx_active_next = 1'b0;
            rx_cd_next     = '0;
            rx_idx_next    = '0;
            rx_shift_next  = '0;
        end else if (!rx_active_reg) begin
            if (!eng_in.rx_level) begin
                // wait 1.25 bit periods to land a quarter into the first data bit
                rx_active_next = 1'b1;
                rx_cd_next     = RX_CD_W'(t_eff) + RX_CD_W'(t_eff >> 2);
                rx_idx_next    = '0;
                rx_shift_next  = '0;
            end
        end else if (rx_cd_reg > RX_CD_W'(1)) begin
            rx_cd_next = rx_cd_reg - 1'b1;
        end else if (rx_idx_reg < BIT_IDX_W'(CHAR_BITS)) begin
            if (eng_in.rx_level) begin
                rx_shift_next[rx_idx_reg[SH_IDX_W-1:0]] = 1'b1;
            end
            rx_idx_next = rx_idx_reg + 1'b1;
            rx_cd_next  = RX_CD_W'(t_eff);
        end else begin
            rx_push        = 1'b1;
            rx_active_next = 1'b0;
            rx_cd_next     = '0;
            rx_idx_next    = '0;
            rx_shift_next  = '0;
        end
    end

    // transmitter
    always_comb begin
        tx_phase_next = tx_phase_reg;
        tx_cd_next    = tx_cd_reg;
        tx_idx_next   = tx_idx_reg;
        tx_shift_next = tx_shift_reg;
        line_next     = line_reg;
        tx_take       = 1'b0;
        tx_queue      = 1'b0;
        if (!enable) begin
            tx_phase_next = PH_IDLE;
            tx_cd_next    = '0;
            tx_idx_next   = '0;
            tx_shift_next = '0;
            line_next     = 1'b1;
            tx_queue      = eng_in.tx_push;
        end else begin
            if (tx_phase_reg != PH_IDLE) begin
                if (tx_cd_reg > TX_CD_W'(1)) begin
                    tx_cd_next = tx_cd_reg - 1'b1;
                end else if (tx_phase_reg == PH_DATA) begin
                    if (tx_idx_reg <= BIT_IDX_W'(CHAR_BITS)) begin
                        line_next     = tx_shift_reg[0];
                        tx_shift_next = tx_shift_reg >> 1;
                        tx_idx_next   = tx_idx_reg + 1'b1;
                        tx_cd_next    = t_eff;
                    end else begin
                        line_next     = 1'b1;
                        tx_phase_next = PH_STOP;
                        tx_cd_next    = t_eff;
                    end
                end else begin
                    // stop phase; unused code 3 ends the same way
                    tx_phase_next = PH_IDLE;
                    tx_cd_next    = '0;
                    tx_idx_next   = '0;
                    line_next     = 1'b1;
                end
            end
            if ((tx_phase_next == PH_IDLE) && eng_in.tx_avail) begin
                tx_take       = 1'b1;
                tx_shift_next = eng_in.tx_head[CHAR_BITS-1:0];
                line_next     = 1'b0;
                tx_idx_next   = BIT_IDX_W'(1);
                tx_cd_next    = t_eff;
                tx_phase_next = PH_DATA;
            end
            if (eng_in.tx_push) begin
                if (tx_phase_next == PH_IDLE) begin
                    tx_shift_next = eng_in.tx_byte[CHAR_BITS-1:0];
                    line_next     = 1'b0;
                    tx_idx_next   = BIT_IDX_W'(1);
                    tx_cd_next    = t_eff;
                    tx_phase_next = PH_DATA;
                end else begin
                    tx_queue = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_active_reg <= 1'b0;
            rx_cd_reg     <= '0;
            rx_idx_reg    <= '0;
            rx_shift_reg  <= '0;
            tx_phase_reg  <= PH_IDLE;
            tx_cd_reg     <= '0;
            tx_idx_reg    <= '0;
            tx_shift_reg  <= '0;
            line_reg      <= 1'b1;
        end else if (step) begin
            rx_active_reg <= rx_active_next;
            rx_cd_reg     <= rx_cd_next;
            rx_idx_reg    <= rx_idx_next;
            rx_shift_reg  <= rx_shift_next;
            tx_phase_reg  <= tx_phase_next;
            tx_cd_reg     <= tx_cd_next;
            tx_idx_reg    <= tx_idx_next;
            tx_shift_reg  <= tx_shift_next;
            line_reg      <= line_next;
        end
    end

    assign eng_out.rx_push  = rx_push;
    assign eng_out.rx_data  = BYTE_W'(rx_shift_reg);
    assign eng_out.tx_take  = tx_take;
    assign eng_out.tx_queue = tx_queue;
    assign eng_out.line     = line_next;
    assign eng_out.busy     = (tx_phase_next != PH_IDLE);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for the tick-driven UART transceiver: random line levels shaped as
// 8N1 frames, tx pushes, pops and clears, checked tick by tick against an in-bench model.
// Depends on tut_pkg and timer_tick_uart_transceiver.
`default_nettype none

module testbench;
    import tut_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 200;

    typedef enum logic [1:0] {TXS_IDLE, TXS_DATA, TXS_STOP} tx_state_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    timer_tick_uart_transceiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ticks waiting to be driven, and line responses still owed by the block
    req_t tick_q[$];
    rsp_t resp_q[$];
    int   ticks_queued = 0;
    int   ticks_taken  = 0;
    int   line_end     = 0;
    int   err_count    = 0;
    int   push_pct     = 20;
    int   pop_pct      = 10;
    bit   gaps_on      = 1'b1;
    bit   hold_req     = 1'b0;
    int   hold_left    = 0;
    int   stall_left   = 0;
    int   send_gap     = 0;
    logic s_fire       = 1'b0;

    // model copy of the registers and the engines
    logic [TPB_W-1:0] tpb_cfg = '0;
    logic             uart_en = 1'b0;
    logic [7:0]       rx_cd = '0, rx_sh = '0, tx_cd = '0, tx_sh = '0;
    logic [3:0]       rx_idx = '0, tx_idx = '0;
    logic             rx_on = 1'b0;
    logic             line_lvl = 1'b1;
    tx_state_t        tx_st = TXS_IDLE;
    logic [7:0]       rx_fifo[$];
    logic [7:0]       tx_fifo[$];

    task automatic start_frame(input logic [7:0] b, input logic [7:0] t);
        tx_sh    = b;
        line_lvl = 1'b0;
        tx_idx   = 4'd1;
        tx_cd    = t;
        tx_st    = TXS_DATA;
    endtask

    // one timer tick: host side of rx FIFO, then receiver, transmitter, push
    task automatic uart_tick(input req_t rq, output rsp_t rs);
        logic [7:0] t;
        logic [7:0] got;
        logic       got_ok, rx_drop, tx_drop;
        t = (tpb_cfg == 0) ? 8'd1 : {1'b0, tpb_cfg};
        got = '0;
        got_ok = 1'b0;
        rx_drop = 1'b0;
        tx_drop = 1'b0;

        if (rq.rx_clear) begin
            rx_fifo.delete();
        end else if (rq.rx_pop && rx_fifo.size() > 0) begin
            got = rx_fifo.pop_front();
            got_ok = 1'b1;
        end

        if (!uart_en) begin
            rx_on = 1'b0; rx_cd = '0; rx_idx = '0; rx_sh = '0;
        end else if (!rx_on) begin
            if (!rq.rx_level) begin
                // start edge: wait ~1.25 bit periods to land a quarter into the first data bit
                rx_on = 1'b1;
                rx_cd = t + (t >> 2);
                rx_idx = '0;
                rx_sh = '0;
            end
        end else if (rx_cd > 1) begin
            rx_cd = rx_cd - 1'b1;
        end else if (rx_idx < CHAR_BITS) begin
            if (rq.rx_level) rx_sh[rx_idx[2:0]] = 1'b1;
            rx_idx = rx_idx + 1'b1;
            rx_cd = t;
        end else begin
            if (rx_fifo.size() < FIFO_DEPTH) rx_fifo.push_back(rx_sh);
            else rx_drop = 1'b1;
            rx_on = 1'b0; rx_cd = '0; rx_idx = '0; rx_sh = '0;
        end

        if (!uart_en) begin
            tx_st = TXS_IDLE; tx_cd = '0; tx_idx = '0; tx_sh = '0;
            line_lvl = 1'b1;
            if (rq.tx_push) begin
                if (tx_fifo.size() < FIFO_DEPTH) tx_fifo.push_back(rq.tx_byte);
                else tx_drop = 1'b1;
            end
        end else begin
            if (tx_st != TXS_IDLE) begin
                if (tx_cd > 1) begin
                    tx_cd = tx_cd - 1'b1;
                end else if (tx_st == TXS_DATA) begin
                    if (tx_idx <= CHAR_BITS) begin
                        line_lvl = tx_sh[0];
                        tx_sh = tx_sh >> 1;
                        tx_idx = tx_idx + 1'b1;
                        tx_cd = t;
                    end else begin
                        line_lvl = 1'b1;
                        tx_st = TXS_STOP;
                        tx_cd = t;
                    end
                end else begin
                    tx_st = TXS_IDLE; tx_cd = '0; tx_idx = '0;
                    line_lvl = 1'b1;
                end
            end
            if (tx_st == TXS_IDLE && tx_fifo.size() > 0) start_frame(tx_fifo.pop_front(), t);
            if (rq.tx_push) begin
                if (tx_st == TXS_IDLE) start_frame(rq.tx_byte, t);
                else if (tx_fifo.size() < FIFO_DEPTH) tx_fifo.push_back(rq.tx_byte);
                else tx_drop = 1'b1;
            end
        end

        rs.tx_level      = line_lvl;
        rs.rx_byte       = got;
        rs.rx_byte_valid = got_ok;
        rs.rx_fill       = FILL_W'(rx_fifo.size());
        rs.tx_fill       = FILL_W'(tx_fifo.size());
        rs.rx_overflow   = rx_drop;
        rs.tx_overflow   = tx_drop;
        rs.tx_busy       = (tx_st != TXS_IDLE);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic check_field(input string what, input int want, input int seen);
        if (want != seen) begin
            err_count++;
            // keep the log bounded when the block is badly off
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
        end
    endtask

    // request driver
    always @(negedge aclk) begin
        logic [S_TDATA_W-1:0] word;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap--;
            end else if (tick_q.size() > 0) begin
                word = '0;
                word[REQ_W-1:0] = tick_q.pop_front();
                s_tdata  <= word;
                s_tvalid <= 1'b1;
                send_gap = gaps_on ? pick_gap() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 80;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            stall_left = gaps_on ? pick_gap() : 0;
        end
    end

    // results are checked before the same edge's request is modeled
    always @(posedge aclk) begin
        rsp_t seen, want;
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                seen = rsp_t'(m_tdata[RSP_W-1:0]);
                if (resp_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, got %h", $time, seen);
                end else begin
                    want = resp_q.pop_front();
                    check_field("tx_level",      want.tx_level,      seen.tx_level);
                    check_field("rx_byte",       want.rx_byte,       seen.rx_byte);
                    check_field("rx_byte_valid", want.rx_byte_valid, seen.rx_byte_valid);
                    check_field("rx_fill",       want.rx_fill,       seen.rx_fill);
                    check_field("tx_fill",       want.tx_fill,       seen.tx_fill);
                    check_field("rx_overflow",   want.rx_overflow,   seen.rx_overflow);
                    check_field("tx_overflow",   want.tx_overflow,   seen.tx_overflow);
                    check_field("tx_busy",       want.tx_busy,       seen.tx_busy);
                end
            end
            if (s_tvalid && s_tready) begin
                uart_tick(req_t'(s_tdata[REQ_W-1:0]), want);
                resp_q.push_back(want);
                ticks_taken++;
            end
        end
    end

    initial begin
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic put(input logic lvl, input logic push, input logic [7:0] b,
                       input logic pop, input logic clr);
        req_t r;
        r.rx_level = lvl;
        r.tx_push  = push;
        r.tx_byte  = b;
        r.rx_pop   = pop;
        r.rx_clear = clr;
        tick_q.push_back(r);
        ticks_queued++;
    endtask

    task automatic emit(input logic lvl);
        if (ticks_queued < line_end)
            put(lvl, $urandom_range(0, 99) < push_pct, 8'($urandom),
                $urandom_range(0, 99) < pop_pct, $urandom_range(0, 199) == 0);
    endtask

    // receive line: mostly clean frames, some cut-off frames and glitches
    task automatic run_line(input int t_eff, input int n);
        int kind, bits;
        logic [7:0] data;
        line_end = ticks_queued + n;
        while (ticks_queued < line_end) begin
            kind = $urandom_range(0, 99);
            data = 8'($urandom);
            if (kind < 80) begin
                repeat (t_eff) emit(1'b0);
                for (int i = 0; i < CHAR_BITS; i++) repeat (t_eff) emit(data[i]);
                repeat (t_eff + $urandom_range(0, 2 * t_eff)) emit(1'b1);
            end else if (kind < 90) begin
                bits = $urandom_range(0, CHAR_BITS - 1);
                repeat (t_eff) emit(1'b0);
                for (int i = 0; i < bits; i++) repeat (t_eff) emit(data[i]);
            end else begin
                repeat ($urandom_range(1, 3 * t_eff)) emit(1'($urandom));
            end
        end
    endtask

    task automatic wait_idle();
        while (ticks_taken != ticks_queued || resp_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        if (idx == REG_TICKS_PER_BIT) tpb_cfg = TPB_W'(val);
        else uart_en = 1'(val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int tpb, input logic en, input int n,
                             input int push, input int pop, input bit idle_gaps);
        wait_idle();
        write_reg(REG_TICKS_PER_BIT, tpb);
        write_reg(REG_ENABLE, en);
        push_pct = push;
        pop_pct  = pop;
        gaps_on  = idle_gaps;
        run_line((tpb == 0) ? 1 : tpb, n);
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // disabled: pushes pile up until the tx FIFO overflows, pop on empty,
        // clear together with pop
        put(1'b0, 1'b1, 8'h00, 1'b1, 1'b0);
        put(1'b1, 1'b1, 8'hFF, 1'b1, 1'b1);
        for (int i = 0; i < 16; i++) put(i[0], 1'b1, i[0] ? 8'hAA : 8'h55, 1'b0, 1'b0);
        wait_idle();
        // enabled with zero ticks per bit (runs as one)
        write_reg(REG_ENABLE, 1);
        put(1'b0, 1'b1, 8'h81, 1'b1, 1'b0);
        put(1'b1, 1'b0, 8'h00, 1'b1, 1'b1);
        repeat (3) put(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);

        run_phase(0,   1'b1, 300, 20, 10, 1'b1);
        run_phase(1,   1'b1, 300, 50, 3,  1'b1);
        run_phase(3,   1'b1, 400, 10, 30, 1'b1);
        hold_req = 1'b1;
        run_phase(127, 1'b1, 300, 30, 20, 1'b1);
        run_phase(2,   1'b0, 150, 30, 20, 1'b1);
        run_phase(5,   1'b1, 200, 5,  20, 1'b0);
        // sender sits out until the block has answered everything
        wait_idle();
        run_line(5, 200);
        run_phase(2,   1'b1, 100, 15, 15, 1'b1);
        wait_idle();

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== timer_tick_uart_transceiver.f =====
hdl/tut_pkg.sv
hdl/tut_fifo_mem.sv
hdl/tut_engine.sv
hdl/timer_tick_uart_transceiver.sv
tb/testbench.sv
